### hw/rtl/sffm_pkg.sv
// ----------------------------------------------------------------------------
// sffm_pkg
// Shared types and constants of the sensor fault and freeze monitor.
// ----------------------------------------------------------------------------
package sffm_pkg;

  localparam int unsigned SffmChannels = 4;

  localparam int unsigned ChanW   = 2;
  localparam int unsigned RawW    = 12;
  localparam int unsigned TenthsW = 12;
  localparam int unsigned ActW    = 3;
  localparam int unsigned ErrCntW = 3;
  localparam int unsigned FrzCntW = 10;
  localparam int unsigned CfgW    = 10;

  localparam logic signed [RawW-1:0] DisconnectedRaw = -12'sd2032;

  localparam logic [ActW-1:0]    ActiveReset      = 3'd0;
  localparam logic [ErrCntW-1:0] ErrorLimitReset  = 3'd5;
  localparam logic [FrzCntW-1:0] FreezeLimitReset = 10'd600;

  typedef enum logic [1:0] {
    CfgActiveChannels = 2'd0,
    CfgErrorLimit     = 2'd1,
    CfgFreezeLimit    = 2'd2
  } sffm_cfg_idx_e;

  typedef struct packed {
    logic [ErrCntW-1:0]        err_cnt;
    logic [FrzCntW-1:0]        frz_cnt;
    logic signed [RawW-1:0]    prev_raw;
    logic signed [TenthsW-1:0] tenths;
    logic                      err_flag;
    logic                      frz_flag;
  } sffm_chan_t;

  typedef struct packed {
    logic                      accepted;
    logic signed [TenthsW-1:0] tenths;
    logic                      value_updated;
    logic                      fault_flag;
    logic                      frozen_flag;
    logic                      fault_raised;
    logic                      fault_cleared;
    logic                      freeze_raised;
    logic                      freeze_cleared;
  } sffm_res_t;

endpackage

### hw/rtl/sensor_fault_freeze_monitor.sv
// ----------------------------------------------------------------------------
// sensor_fault_freeze_monitor
// Per-channel disconnect and freeze detection on raw temperature readings.
//
//   channel  | handshake                | payload
//   ---------+--------------------------+-----------------------------------
//   in       | in_valid_i / in_ready_o  | channel_i, raw_reading_i
//   out      | out_valid_o / out_ready_i| out_channel_o .. freeze_cleared_o
//   config   | cfg_we_i (no wait)       | cfg_addr_i, cfg_wdata_i
//
// one request per cycle unless a stalled result holds the input; a request
// passes the input register, then the result register, and the channel state
// read-modify-write happens between the two, so back-to-back readings of one
// channel need no bypass; reset clears all channel state and loads the register defaults
// a stalled output holds one result and one buffered request
// ----------------------------------------------------------------------------
module sensor_fault_freeze_monitor import sffm_pkg::*; #(
  parameter int unsigned CHANNELS = SffmChannels
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [1:0]                cfg_addr_i,
  input  logic [CfgW-1:0]           cfg_wdata_i,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [ChanW-1:0]          channel_i,
  input  logic signed [RawW-1:0]    raw_reading_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [ChanW-1:0]          out_channel_o,
  output logic                      accepted_o,
  output logic signed [TenthsW-1:0] tenths_value_o,
  output logic                      value_updated_o,
  output logic                      fault_flag_o,
  output logic                      frozen_flag_o,
  output logic                      fault_raised_o,
  output logic                      fault_cleared_o,
  output logic                      freeze_raised_o,
  output logic                      freeze_cleared_o
);

  logic [ActW-1:0]        active_q;
  logic [ErrCntW-1:0]     err_limit_q;
  logic [FrzCntW-1:0]     frz_limit_q;

  logic                   s1_valid_q;
  logic [ChanW-1:0]       s1_chan_q;
  logic signed [RawW-1:0] s1_raw_q;
  logic                   s1_adv;

  logic                   out_valid_q;
  logic [ChanW-1:0]       out_chan_q;
  sffm_res_t              out_res_q;

  sffm_chan_t             st_rd;
  sffm_chan_t             st_nxt;
  sffm_res_t              res_d;
  logic                   upd_en;

  // configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q    <= ActiveReset;
      err_limit_q <= ErrorLimitReset;
      frz_limit_q <= FreezeLimitReset;
    end else if (cfg_we_i) begin
      case (sffm_cfg_idx_e'(cfg_addr_i))
        CfgActiveChannels: active_q    <= cfg_wdata_i[ActW-1:0];
        CfgErrorLimit:     err_limit_q <= cfg_wdata_i[ErrCntW-1:0];
        CfgFreezeLimit:    frz_limit_q <= cfg_wdata_i[FrzCntW-1:0];
        default: ;
      endcase
    end
  end

  assign s1_adv     = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || s1_adv;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      s1_chan_q <= channel_i;
      s1_raw_q  <= raw_reading_i;
    end
  end

  sffm_chan_state #(
    .CHANNELS (CHANNELS)
  ) u_state (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_chan_i (s1_chan_q),
    .rd_data_o (st_rd),
    .wr_en_i   (s1_adv && upd_en),
    .wr_chan_i (s1_chan_q),
    .wr_data_i (st_nxt)
  );

  sffm_update #(
    .CHANNELS (CHANNELS)
  ) u_update (
    .chan_i      (s1_chan_q),
    .raw_i       (s1_raw_q),
    .active_i    (active_q),
    .err_limit_i (err_limit_q),
    .frz_limit_i (frz_limit_q),
    .st_i        (st_rd),
    .nxt_o       (st_nxt),
    .wr_en_o     (upd_en),
    .res_o       (res_d)
  );

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (!out_valid_q || out_ready_i) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      out_chan_q <= s1_chan_q;
      out_res_q  <= res_d;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign out_channel_o    = out_chan_q;
  assign accepted_o       = out_res_q.accepted;
  assign tenths_value_o   = out_res_q.tenths;
  assign value_updated_o  = out_res_q.value_updated;
  assign fault_flag_o     = out_res_q.fault_flag;
  assign frozen_flag_o    = out_res_q.frozen_flag;
  assign fault_raised_o   = out_res_q.fault_raised;
  assign fault_cleared_o  = out_res_q.fault_cleared;
  assign freeze_raised_o  = out_res_q.freeze_raised;
  assign freeze_cleared_o = out_res_q.freeze_cleared;

  // ignored channel reports nothing but its number
  a_ignored_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !accepted_o |-> !(value_updated_o || fault_flag_o || frozen_flag_o ||
      fault_raised_o || freeze_raised_o || fault_cleared_o || freeze_cleared_o))
    else $error("ignored channel result carries flags");

  // a good reading always clears the error flag
  a_good_clears_fault: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && value_updated_o |-> !fault_flag_o && !fault_raised_o)
    else $error("good reading left error flag set");

  // raise events agree with the flags they report
  a_raise_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (fault_raised_o || freeze_raised_o) |->
      (!fault_raised_o || fault_flag_o) && (!freeze_raised_o || frozen_flag_o))
    else $error("raise event without flag");

  // input stalls only behind a stalled result
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("input stalled with free result register");

endmodule

### hw/rtl/sffm_chan_state.sv
// ----------------------------------------------------------------------------
// sffm_chan_state
// Per-channel state registers, one read port and one write port.
// ----------------------------------------------------------------------------
module sffm_chan_state import sffm_pkg::*; #(
  parameter int unsigned CHANNELS = SffmChannels
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic [ChanW-1:0] rd_chan_i,
  output sffm_chan_t rd_data_o,
  input  logic       wr_en_i,
  input  logic [ChanW-1:0] wr_chan_i,
  input  sffm_chan_t wr_data_i
);

  localparam int unsigned IdxW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  sffm_chan_t            state_q [CHANNELS];
  logic [IdxW+ChanW-1:0] rd_wide;
  logic [IdxW+ChanW-1:0] wr_wide;
  logic [IdxW-1:0]       rd_idx;
  logic [IdxW-1:0]       wr_idx;

  assign rd_wide = (IdxW+ChanW)'(rd_chan_i);
  assign wr_wide = (IdxW+ChanW)'(wr_chan_i);
  assign rd_idx  = rd_wide[IdxW-1:0];
  assign wr_idx  = wr_wide[IdxW-1:0];

  assign rd_data_o = state_q[rd_idx];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < CHANNELS; i++) begin
        state_q[i] <= '0;
      end
    end else if (wr_en_i) begin
      state_q[wr_idx] <= wr_data_i;
    end
  end

endmodule

### hw/rtl/sffm_update.sv
// ----------------------------------------------------------------------------
// sffm_update
// Next channel state and result fields for one reading.
// ----------------------------------------------------------------------------
module sffm_update import sffm_pkg::*; #(
  parameter int unsigned CHANNELS = SffmChannels
) (
  input  logic [ChanW-1:0]       chan_i,
  input  logic signed [RawW-1:0] raw_i,
  input  logic [ActW-1:0]        active_i,
  input  logic [ErrCntW-1:0]     err_limit_i,
  input  logic [FrzCntW-1:0]     frz_limit_i,
  input  sffm_chan_t             st_i,
  output sffm_chan_t             nxt_o,
  output logic                   wr_en_o,
  output sffm_res_t              res_o
);

  logic                      in_use;
  logic                      is_disc;
  logic [RawW-1:0]           mag;
  logic [14:0]               scaled;
  logic [10:0]               quot;
  logic signed [TenthsW-1:0] conv;
  logic [ErrCntW:0]          err_inc;
  logic [FrzCntW:0]          frz_inc;

  assign in_use  = ({1'b0, chan_i} < active_i) && (32'(chan_i) < 32'(CHANNELS));
  assign is_disc = (raw_i == DisconnectedRaw);
  assign wr_en_o = in_use;

  // tenths = (|raw| * 10 + 8) >> 4, sign restored
  assign mag    = raw_i[RawW-1] ? 12'(-raw_i) : 12'(raw_i);
  assign scaled = (15'(mag) << 3) + (15'(mag) << 1) + 15'd8;
  assign quot   = scaled[14:4];
  assign conv   = raw_i[RawW-1] ? -$signed({1'b0, quot}) : $signed({1'b0, quot});

  assign err_inc = {1'b0, st_i.err_cnt} + 4'd1;
  assign frz_inc = {1'b0, st_i.frz_cnt} + 11'd1;

  always_comb begin
    nxt_o = st_i;
    res_o = '0;

    if (is_disc) begin
      if (err_inc > {1'b0, err_limit_i}) begin
        nxt_o.err_cnt  = err_limit_i;
        nxt_o.err_flag = 1'b1;
      end else begin
        nxt_o.err_cnt = err_inc[ErrCntW-1:0];
      end
    end else begin
      nxt_o.tenths   = conv;
      nxt_o.err_cnt  = '0;
      nxt_o.err_flag = 1'b0;
    end

    if (raw_i == st_i.prev_raw) begin
      if (frz_inc > {1'b0, frz_limit_i}) begin
        nxt_o.frz_cnt  = frz_limit_i;
        nxt_o.frz_flag = 1'b1;
      end else begin
        nxt_o.frz_cnt  = frz_inc[FrzCntW-1:0];
        nxt_o.frz_flag = 1'b0;
      end
    end else begin
      nxt_o.frz_cnt  = '0;
      nxt_o.prev_raw = raw_i;
      nxt_o.frz_flag = 1'b0;
    end

    if (in_use) begin
      res_o.accepted       = 1'b1;
      res_o.tenths         = nxt_o.tenths;
      res_o.value_updated  = !is_disc;
      res_o.fault_flag     = nxt_o.err_flag;
      res_o.frozen_flag    = nxt_o.frz_flag;
      res_o.fault_raised   = !st_i.err_flag && nxt_o.err_flag;
      res_o.fault_cleared  = st_i.err_flag && !nxt_o.err_flag;
      res_o.freeze_raised  = !st_i.frz_flag && nxt_o.frz_flag;
      res_o.freeze_cleared = st_i.frz_flag && !nxt_o.frz_flag;
    end
  end

endmodule

### tb/sv/sensor_fault_freeze_monitor_test.sv
// ----------------------------------------------------------------------------
// sensor_fault_freeze_monitor_test
// Self-checking bench for the sensor fault and freeze monitor. A short list
// of directed readings and register writes is walked first, then eight
// phases, the first two with fixed limits and the rest with random limits,
// mix repeated readings, disconnect runs and random codes. Every accepted
// request is run through a local channel model, and each result is compared
// field by field with the oldest expectation, while both handshakes idle at random outside full-rate phases.
// ----------------------------------------------------------------------------
module sensor_fault_freeze_monitor_test;
  import sffm_pkg::*;

  typedef struct packed {
    logic [ChanW-1:0] chan;
    sffm_res_t        res;
  } reading_result_t;

  typedef struct {
    bit                      is_cfg;
    sffm_cfg_idx_e           reg_idx;
    logic [CfgW-1:0]         reg_val;
    logic [ChanW-1:0]        chan;
    logic signed [RawW-1:0]  raw;
    bit                      typed;
    reading_result_t         typed_res;
  } plan_row_t;

  logic                      clk_i = 1'b0;
  logic                      rst_ni = 1'b0;
  logic                      cfg_we_i = 1'b0;
  logic [1:0]                cfg_addr_i = CfgActiveChannels;
  logic [CfgW-1:0]           cfg_wdata_i = '0;
  logic                      in_valid_i = 1'b0;
  logic                      in_ready_o;
  logic [ChanW-1:0]          channel_i = '0;
  logic signed [RawW-1:0]    raw_reading_i = '0;
  logic                      out_valid_o;
  logic                      out_ready_i = 1'b0;
  logic [ChanW-1:0]          out_channel_o;
  logic                      accepted_o;
  logic signed [TenthsW-1:0] tenths_value_o;
  logic                      value_updated_o;
  logic                      fault_flag_o;
  logic                      frozen_flag_o;
  logic                      fault_raised_o;
  logic                      fault_cleared_o;
  logic                      freeze_raised_o;
  logic                      freeze_cleared_o;

  sensor_fault_freeze_monitor dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_addr_i       (cfg_addr_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .channel_i        (channel_i),
    .raw_reading_i    (raw_reading_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .out_channel_o    (out_channel_o),
    .accepted_o       (accepted_o),
    .tenths_value_o   (tenths_value_o),
    .value_updated_o  (value_updated_o),
    .fault_flag_o     (fault_flag_o),
    .frozen_flag_o    (frozen_flag_o),
    .fault_raised_o   (fault_raised_o),
    .fault_cleared_o  (fault_cleared_o),
    .freeze_raised_o  (freeze_raised_o),
    .freeze_cleared_o (freeze_cleared_o)
  );

  sffm_chan_t         chan_state [SffmChannels];
  logic [ActW-1:0]    active_cnt;
  logic [ErrCntW-1:0] err_limit;
  logic [FrzCntW-1:0] frz_limit;

  reading_result_t expected_results [$];
  plan_row_t       plan_q [$];
  int              fail_count = 0;
  int              ready_hold = 0;
  bit              full_rate = 1'b0;
  bit              sent_since_drain = 1'b0;

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 24);
  endfunction

  function automatic reading_result_t mk_result(logic [ChanW-1:0] ch, logic acc, int tenths,
                                                logic upd, logic [5:0] ev);
    reading_result_t r;
    r = '0;
    r.chan = ch;
    r.res.accepted = acc;
    r.res.tenths = TenthsW'(tenths);
    r.res.value_updated = upd;
    {r.res.fault_flag, r.res.frozen_flag, r.res.fault_raised, r.res.fault_cleared,
     r.res.freeze_raised, r.res.freeze_cleared} = ev;
    return r;
  endfunction

  // channel model: one reading in, one result out, state updated in place
  function automatic reading_result_t predict_reading(logic [ChanW-1:0] ch,
                                                      logic signed [RawW-1:0] raw);
    reading_result_t r;
    sffm_chan_t      s;
    int              eff;
    int              cnt;
    int              rv;
    int              mag;
    int              q;
    logic            old_err;
    logic            old_frz;
    logic            upd;
    r = '0;
    r.chan = ch;
    eff = (active_cnt > SffmChannels) ? SffmChannels : active_cnt;
    if (ch >= eff) return r;
    s = chan_state[ch];
    old_err = s.err_flag;
    old_frz = s.frz_flag;
    upd = 1'b0;
    if (raw == DisconnectedRaw) begin
      cnt = s.err_cnt + 1;
      if (cnt > err_limit) begin
        cnt = err_limit;
        s.err_flag = 1'b1;
      end
      s.err_cnt = cnt[ErrCntW-1:0];
    end else begin
      rv = raw;
      mag = (rv < 0) ? -rv : rv;
      q = (mag * 10 + 8) >> 4;
      s.tenths = TenthsW'((rv < 0) ? -q : q);
      s.err_cnt = '0;
      s.err_flag = 1'b0;
      upd = 1'b1;
    end
    if (raw == s.prev_raw) begin
      cnt = s.frz_cnt + 1;
      if (cnt > frz_limit) begin
        cnt = frz_limit;
        s.frz_flag = 1'b1;
      end else begin
        s.frz_flag = 1'b0;
      end
      s.frz_cnt = cnt[FrzCntW-1:0];
    end else begin
      s.frz_cnt = '0;
      s.prev_raw = raw;
      s.frz_flag = 1'b0;
    end
    chan_state[ch] = s;
    r.res.accepted = 1'b1;
    r.res.tenths = s.tenths;
    r.res.value_updated = upd;
    r.res.fault_flag = s.err_flag;
    r.res.frozen_flag = s.frz_flag;
    r.res.fault_raised = !old_err && s.err_flag;
    r.res.fault_cleared = old_err && !s.err_flag;
    r.res.freeze_raised = !old_frz && s.frz_flag;
    r.res.freeze_cleared = old_frz && !s.frz_flag;
    return r;
  endfunction

  function automatic void check_field(string name, int e, int a);
    if (e != a) begin
      $error("%s mismatch: expected %0d, actual %0d", name, e, a);
      fail_count++;
    end
  endfunction

  function automatic void plan_cfg(sffm_cfg_idx_e idx, logic [CfgW-1:0] val);
    plan_row_t p;
    p.is_cfg = 1'b1;
    p.reg_idx = idx;
    p.reg_val = val;
    p.chan = '0;
    p.raw = '0;
    p.typed = 1'b0;
    p.typed_res = '0;
    plan_q.push_back(p);
  endfunction

  function automatic void plan_reading(logic [ChanW-1:0] ch, logic signed [RawW-1:0] raw,
                                       bit typed, reading_result_t res);
    plan_row_t p;
    p.is_cfg = 1'b0;
    p.reg_idx = CfgActiveChannels;
    p.reg_val = '0;
    p.chan = ch;
    p.raw = raw;
    p.typed = typed;
    p.typed_res = res;
    plan_q.push_back(p);
  endfunction

  // result side: random stalls, or always ready in full-rate stretches
  always @(posedge clk_i) begin
    if (ready_hold > 0) begin
      ready_hold <= ready_hold - 1;
    end else if (full_rate) begin
      out_ready_i <= 1'b1;
    end else begin
      out_ready_i <= ($urandom_range(0, 2) != 0);
      ready_hold <= pick_gap();
    end
  end

  always @(posedge clk_i) begin
    reading_result_t e;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_results.size() == 0) begin
        $error("unexpected result on channel %0d", out_channel_o);
        fail_count++;
      end else begin
        e = expected_results.pop_front();
        check_field("out_channel", e.chan, out_channel_o);
        check_field("accepted", e.res.accepted, accepted_o);
        check_field("tenths_value", e.res.tenths, tenths_value_o);
        check_field("value_updated", e.res.value_updated, value_updated_o);
        check_field("fault_flag", e.res.fault_flag, fault_flag_o);
        check_field("frozen_flag", e.res.frozen_flag, frozen_flag_o);
        check_field("fault_raised", e.res.fault_raised, fault_raised_o);
        check_field("fault_cleared", e.res.fault_cleared, fault_cleared_o);
        check_field("freeze_raised", e.res.freeze_raised, freeze_raised_o);
        check_field("freeze_cleared", e.res.freeze_cleared, freeze_cleared_o);
      end
    end
  end

  task automatic idle_sender(int n);
    if (n > 0) begin
      in_valid_i <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    sent_since_drain = 1'b0;
  endtask

  task automatic cfg_write(sffm_cfg_idx_e idx, logic [CfgW-1:0] val);
    if (sent_since_drain) wait_drained();
    cfg_we_i <= 1'b1;
    cfg_addr_i <= idx;
    cfg_wdata_i <= val;
    case (idx)
      CfgActiveChannels: active_cnt = val[ActW-1:0];
      CfgErrorLimit:     err_limit = val[ErrCntW-1:0];
      CfgFreezeLimit:    frz_limit = val[FrzCntW-1:0];
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  task automatic send_reading(logic [ChanW-1:0] ch, logic signed [RawW-1:0] raw,
                              bit use_typed, reading_result_t typed_res);
    reading_result_t predicted;
    cfg_we_i <= 1'b0;
    in_valid_i <= 1'b1;
    channel_i <= ch;
    raw_reading_i <= raw;
    do @(posedge clk_i); while (!in_ready_o);
    predicted = predict_reading(ch, raw);
    expected_results.push_back(use_typed ? typed_res : predicted);
    sent_since_drain = 1'b1;
  endtask

  initial begin
    int                     r;
    int                     phase;
    int                     counted;
    int                     target;
    int                     eff;
    logic [ChanW-1:0]       ch;
    logic signed [RawW-1:0] raw;
    logic [CfgW-1:0]        act_v;
    logic [CfgW-1:0]        el_v;
    logic [CfgW-1:0]        fl_v;
    plan_row_t              row;

    active_cnt = ActiveReset;
    err_limit = ErrorLimitReset;
    frz_limit = FreezeLimitReset;
    for (int i = 0; i < SffmChannels; i++) chan_state[i] = '0;

    // no channel active after reset
    plan_reading(0, 0, 1'b1, mk_result(0, 1'b0, 0, 1'b0, 6'b000000));
    plan_reading(3, 2047, 1'b1, mk_result(3, 1'b0, 0, 1'b0, 6'b000000));
    plan_reading(1, DisconnectedRaw, 1'b1, mk_result(1, 1'b0, 0, 1'b0, 6'b000000));
    // zero limits: flags rise on the first disconnect or repeat
    plan_cfg(CfgActiveChannels, 4);
    plan_cfg(CfgErrorLimit, 0);
    plan_cfg(CfgFreezeLimit, 0);
    plan_reading(0, 2047, 1'b1, mk_result(0, 1'b1, 1279, 1'b1, 6'b000000));
    plan_reading(0, 2047, 1'b1, mk_result(0, 1'b1, 1279, 1'b1, 6'b010010));
    plan_reading(0, -2048, 1'b1, mk_result(0, 1'b1, -1280, 1'b1, 6'b000001));
    plan_reading(1, DisconnectedRaw, 1'b1, mk_result(1, 1'b1, 0, 1'b0, 6'b101000));
    plan_reading(1, DisconnectedRaw, 1'b1, mk_result(1, 1'b1, 0, 1'b0, 6'b110010));
    plan_reading(1, 16, 1'b1, mk_result(1, 1'b1, 10, 1'b1, 6'b000101));
    // rounding, ties away from zero
    plan_reading(2, -1, 1'b0, '0);
    plan_reading(2, 1, 1'b0, '0);
    plan_reading(3, 4, 1'b0, '0);
    plan_reading(3, -4, 1'b0, '0);
    // active count above channel count, maximum limits
    plan_cfg(CfgActiveChannels, 7);
    plan_cfg(CfgErrorLimit, 7);
    plan_cfg(CfgFreezeLimit, 1023);
    plan_reading(2, DisconnectedRaw, 1'b0, '0);
    plan_reading(2, DisconnectedRaw, 1'b0, '0);
    plan_reading(2, DisconnectedRaw, 1'b0, '0);
    plan_reading(3, 2047, 1'b0, '0);
    // limits lowered below the running counts
    plan_cfg(CfgErrorLimit, 1);
    plan_cfg(CfgFreezeLimit, 1);
    plan_reading(2, DisconnectedRaw, 1'b0, '0);
    // upper channels ignored
    plan_cfg(CfgActiveChannels, 2);
    plan_reading(2, 5, 1'b1, mk_result(2, 1'b0, 0, 1'b0, 6'b000000));
    plan_reading(3, -2048, 1'b1, mk_result(3, 1'b0, 0, 1'b0, 6'b000000));
    plan_reading(1, -2048, 1'b0, '0);

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (plan_q[i]) begin
      row = plan_q[i];
      if (row.is_cfg) begin
        cfg_write(row.reg_idx, row.reg_val);
      end else begin
        send_reading(row.chan, row.raw, row.typed, row.typed_res);
        idle_sender(pick_gap());
      end
    end

    for (phase = 0; phase < 8; phase++) begin
      if (phase == 0) begin
        act_v = 4;
        el_v = 7;
        fl_v = 1023;
      end else if (phase == 1) begin
        act_v = 4;
        el_v = 0;
        fl_v = 0;
      end else begin
        act_v = CfgW'(($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 7));
        el_v = CfgW'($urandom_range(0, 7));
        r = $urandom_range(0, 99);
        fl_v = CfgW'((r < 70) ? $urandom_range(0, 6) :
                     ((r < 85) ? 1023 : $urandom_range(0, 1023)));
      end
      cfg_write(CfgActiveChannels, act_v);
      cfg_write(CfgErrorLimit, el_v);
      cfg_write(CfgFreezeLimit, fl_v);
      full_rate = ($urandom_range(0, 3) == 0);
      eff = (act_v > SffmChannels) ? SffmChannels : act_v;
      target = (eff == 0) ? 8 : 50;
      counted = 0;
      while (counted < target) begin
        if (eff > 0 && $urandom_range(0, 9) < 8) ch = ChanW'($urandom_range(0, eff - 1));
        else ch = ChanW'($urandom_range(0, 3));
        r = $urandom_range(0, 99);
        if (r < 35) raw = chan_state[ch].prev_raw;
        else if (r < 60) raw = DisconnectedRaw;
        else raw = RawW'($urandom_range(0, 4095));
        send_reading(ch, raw, 1'b0, '0);
        if (eff == 0 || ch < eff) counted++;
        idle_sender(full_rate ? 0 : pick_gap());
      end
    end

    wait_drained();
    if (fail_count == 0 && expected_results.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #3000000;
    $display("tb: failure");
    $finish;
  end

endmodule

### filelist.f
hw/rtl/sffm_pkg.sv
hw/rtl/sffm_chan_state.sv
hw/rtl/sffm_update.sv
hw/rtl/sensor_fault_freeze_monitor.sv
tb/sv/sensor_fault_freeze_monitor_test.sv
